// File: hdl/md_pkg.sv
`timescale 1ns / 1ps

package md_pkg;

    localparam int VALUE_WIDTH = 31;
    localparam int IDX_W       = $clog2(VALUE_WIDTH);

    typedef logic [VALUE_WIDTH-1:0] t_value;
    typedef logic [IDX_W-1:0]       t_idx;

    localparam t_value MOD_RESET = t_value'(2);
    localparam t_value ONE       = t_value'(1);
    localparam t_idx   IDX_TOP   = t_idx'(VALUE_WIDTH - 1);

    typedef struct packed {
        logic   start;
        t_value num;
        t_value den;
        t_value coef;
    } t_div_req;

    typedef struct packed {
        logic   done;
        t_value rem;
        t_value prod;
    } t_div_rsp;

endpackage

// File: hdl/md_in_if.sv
`timescale 1ns / 1ps

interface md_in_if import md_pkg::*; ();
    logic   valid;
    logic   ready;
    t_value dividend;
    t_value divisor;

    modport source (output valid, output dividend, output divisor, input ready);
    modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

// File: hdl/md_out_if.sv
`timescale 1ns / 1ps

interface md_out_if import md_pkg::*; ();
    logic   valid;
    logic   ready;
    t_value quotient;
    logic   undefined;

    modport source (output valid, output quotient, output undefined, input ready);
    modport sink   (input valid, input quotient, input undefined, output ready);
endinterface

// File: hdl/md_div.sv
`timescale 1ns / 1ps

module md_div import md_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ALIGN = 2'd1;
    localparam logic [1:0] S_SUB   = 2'd2;

    logic [1:0]           r_state, n_state;
    logic                 r_done,  n_done;
    t_value               r_rem,   n_rem;
    logic [VALUE_WIDTH:0] r_den,   n_den;
    t_value               r_coef,  n_coef;
    t_value               r_prod,  n_prod;
    t_idx                 r_k,     n_k;

    logic [VALUE_WIDTH:0] w_den_dbl;
    logic [VALUE_WIDTH:0] w_rem_ext;
    logic [VALUE_WIDTH:0] w_diff;
    logic                 w_fit;
    logic                 w_ge;
    t_value               w_acc;

    assign w_den_dbl = {r_den[VALUE_WIDTH-1:0], 1'b0};
    assign w_rem_ext = {1'b0, r_rem};
    assign w_fit     = (w_den_dbl <= w_rem_ext);
    assign w_ge      = (w_rem_ext >= r_den);
    assign w_diff    = w_rem_ext - r_den;
    assign w_acc     = {r_prod[VALUE_WIDTH-2:0], 1'b0} + (w_ge ? r_coef : '0);

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        n_rem   = r_rem;
        n_den   = r_den;
        n_coef  = r_coef;
        n_prod  = r_prod;
        n_k     = r_k;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    n_rem   = i_req.num;
                    n_den   = {1'b0, i_req.den};
                    n_coef  = i_req.coef;
                    n_prod  = '0;
                    n_k     = '0;
                    n_state = S_ALIGN;
                end
            end
            S_ALIGN: begin
                if (w_fit) begin
                    n_den = w_den_dbl;
                    n_k   = r_k + 1'b1;
                end else begin
                    n_state = S_SUB;
                end
            end
            S_SUB: begin
                if (w_ge) begin
                    n_rem = w_diff[VALUE_WIDTH-1:0];
                end
                n_prod = w_acc;
                n_den  = r_den >> 1;
                if (r_k == '0) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end else begin
                    n_k = r_k - 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_coef <= n_coef;
        r_prod <= n_prod;
        r_k    <= n_k;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;
    assign o_rsp.prod = r_prod;

endmodule

// File: hdl/modular_divide.sv
// Modular divider: quotient = dividend * divisor^-1 mod modulus.
// Input channel i_in carries dividend and divisor; output channel o_out
// carries quotient and the undefined flag, one result beat per input beat.
// The modulus is loaded through i_cfg_wr_en / i_cfg_wr_data; the user
// must do so only while idle, as the block does not enforce it. One item
// is in flight at a time: i_in.ready is high only when idle. Each item
// runs in steps: the dividend and the divisor are each reduced mod the
// modulus, each with an alignment shift; the Euclid steps then find the
// inverse; a double-and-add pass over the 31 bits of the inverse then
// forms the product mod the modulus. The reductions and the Euclid steps
// share one shift-subtract divider, which also forms q*t for the coefficient
// update, one quotient bit per cycle; Fibonacci-like operands run longest.
// A zero modulus gives undefined at once, in the cycle after acceptance.
// The result sits in an output register until o_out.ready; a stalled
// receiver holds the block with the result unchanged.
// Reset (synchronous, active low) returns to idle and sets the modulus to 2.
`timescale 1ns / 1ps

module modular_divide import md_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_wr_en,
    input  t_value   i_cfg_wr_data,
    md_in_if.sink    i_in,
    md_out_if.source o_out
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_RED_A   = 4'd1;
    localparam logic [3:0] S_RED_B   = 4'd2;
    localparam logic [3:0] S_EUC_CHK = 4'd3;
    localparam logic [3:0] S_EUC_DIV = 4'd4;
    localparam logic [3:0] S_FIN     = 4'd5;
    localparam logic [3:0] S_MUL_DBL = 4'd6;
    localparam logic [3:0] S_MUL_ADD = 4'd7;
    localparam logic [3:0] S_OUT     = 4'd8;

    logic [3:0] r_state, n_state;
    t_value     r_modulus;
    t_value     r_a,     n_a;
    t_value     r_r0,    n_r0;
    t_value     r_r1,    n_r1;
    t_value     r_t0,    n_t0;
    t_value     r_t1,    n_t1;
    logic       r_neg,   n_neg;
    t_value     r_inv,   n_inv;
    t_value     r_acc,   n_acc;
    t_idx       r_idx,   n_idx;
    t_value     r_quot,  n_quot;
    logic       r_undef, n_undef;

    t_div_req   w_req;
    t_div_rsp   w_rsp;

    t_value               w_addend;
    logic [VALUE_WIDTH:0] w_sum;
    logic [VALUE_WIDTH:0] w_mod_ext;
    t_value               w_sum_red;
    t_value               w_inv;
    logic                 w_in_acc;

    md_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_in_acc  = i_in.valid && i_in.ready;
    assign w_addend  = (r_state == S_MUL_DBL) ? r_acc : r_a;
    assign w_sum     = {1'b0, r_acc} + {1'b0, w_addend};
    assign w_mod_ext = {1'b0, r_modulus};
    assign w_sum_red = (w_sum >= w_mod_ext) ? t_value'(w_sum - w_mod_ext)
                                            : w_sum[VALUE_WIDTH-1:0];
    assign w_inv     = (r_neg && (r_t0 != '0)) ? (r_modulus - r_t0) : r_t0;

    always_comb begin
        n_state   = r_state;
        n_a       = r_a;
        n_r0      = r_r0;
        n_r1      = r_r1;
        n_t0      = r_t0;
        n_t1      = r_t1;
        n_neg     = r_neg;
        n_inv     = r_inv;
        n_acc     = r_acc;
        n_idx     = r_idx;
        n_quot    = r_quot;
        n_undef   = r_undef;
        w_req.start = 1'b0;
        w_req.num   = r_r0;
        w_req.den   = r_r1;
        w_req.coef  = r_t1;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (r_modulus == '0) begin
                        n_quot  = '0;
                        n_undef = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        n_r1        = i_in.divisor;
                        w_req.start = 1'b1;
                        w_req.num   = i_in.dividend;
                        w_req.den   = r_modulus;
                        w_req.coef  = '0;
                        n_state     = S_RED_A;
                    end
                end
            end
            S_RED_A: begin
                if (w_rsp.done) begin
                    n_a         = w_rsp.rem;
                    w_req.start = 1'b1;
                    w_req.num   = r_r1;
                    w_req.den   = r_modulus;
                    w_req.coef  = '0;
                    n_state     = S_RED_B;
                end
            end
            S_RED_B: begin
                if (w_rsp.done) begin
                    n_r0    = r_modulus;
                    n_r1    = w_rsp.rem;
                    n_t0    = '0;
                    n_t1    = ONE;
                    n_neg   = 1'b1;
                    n_state = S_EUC_CHK;
                end
            end
            S_EUC_CHK: begin
                if (r_r1 == '0) begin
                    n_state = S_FIN;
                end else begin
                    w_req.start = 1'b1;
                    n_state     = S_EUC_DIV;
                end
            end
            S_EUC_DIV: begin
                if (w_rsp.done) begin
                    n_r0    = r_r1;
                    n_r1    = w_rsp.rem;
                    n_t0    = r_t1;
                    n_t1    = r_t0 + w_rsp.prod;
                    n_neg   = !r_neg;
                    n_state = S_EUC_CHK;
                end
            end
            S_FIN: begin
                if (r_r0 != ONE) begin
                    n_quot  = '0;
                    n_undef = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_inv   = w_inv;
                    n_acc   = '0;
                    n_idx   = IDX_TOP;
                    n_state = S_MUL_DBL;
                end
            end
            S_MUL_DBL: begin
                n_acc   = w_sum_red;
                n_state = S_MUL_ADD;
            end
            S_MUL_ADD: begin
                if (r_inv[r_idx]) begin
                    n_acc = w_sum_red;
                end
                if (r_idx == '0) begin
                    n_quot  = r_inv[r_idx] ? w_sum_red : r_acc;
                    n_undef = 1'b0;
                    n_state = S_OUT;
                end else begin
                    n_idx   = r_idx - 1'b1;
                    n_state = S_MUL_DBL;
                end
            end
            S_OUT: begin
                if (o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_modulus <= MOD_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_modulus <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a     <= n_a;
        r_r0    <= n_r0;
        r_r1    <= n_r1;
        r_t0    <= n_t0;
        r_t1    <= n_t1;
        r_neg   <= n_neg;
        r_inv   <= n_inv;
        r_acc   <= n_acc;
        r_idx   <= n_idx;
        r_quot  <= n_quot;
        r_undef <= n_undef;
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = (r_state == S_OUT);
    assign o_out.quotient  = r_quot;
    assign o_out.undefined = r_undef;

endmodule

// File: hdl/md_chk.sv
`timescale 1ns / 1ps

module md_chk import md_pkg::*; (
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   i_in_valid,
    input logic   i_in_ready,
    input logic   i_out_valid,
    input logic   i_out_ready,
    input t_value i_out_quotient,
    input logic   i_out_undefined
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_quotient)
            && $stable(i_out_undefined))
        else $error("stalled result beat changed");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input ready while a result is pending");

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken again before the result");

    a_undef_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_undefined |-> i_out_quotient == '0)
        else $error("undefined result with nonzero quotient");

    a_out_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready |=> !i_out_valid)
        else $error("result beat repeated");

endmodule

bind modular_divide md_chk u_md_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_quotient  (o_out.quotient),
    .i_out_undefined (o_out.undefined)
);
